FILE: hw/rtl/sesel_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sesel_pkg;

    localparam int MAX_PARTICLES_DEF = 64;
    localparam int JACOBI_SWEEPS_DEF = 6;

    localparam int MOM_W     = 16;
    localparam int SUM_W     = 40;
    localparam int N_SUM     = 6;
    localparam int ELEM_IDX_W = 3;
    localparam int TRACE_W   = SUM_W + 1;
    localparam int TK_W      = 32;
    localparam int K_MAX     = TRACE_W - TK_W;
    localparam int K_W       = 4;
    localparam int EL_W      = 32;
    localparam int SPH_W     = 16;

    localparam int DIVIDEND_W = 60;
    localparam int DIVISOR_W  = 33;
    localparam int QUOT_W     = 29;
    localparam int RAD_W      = 64;
    localparam int ROOT_W     = 32;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_ENABLE    = 2'd2;

    localparam logic [SPH_W-1:0] LOWER_RST = 16'd0;
    localparam logic [SPH_W-1:0] UPPER_RST = 16'd32768;
    localparam logic [SPH_W-1:0] SPH_MAX   = 16'd32768;

    localparam logic [ELEM_IDX_W-1:0] ELEM_LAST = 3'd5;

    typedef enum logic [1:0] {
        PAIR_01,
        PAIR_02,
        PAIR_12
    } t_pair;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_ACCUM,
        OP_TRACE,
        OP_KSEL,
        OP_NORM_START,
        OP_NORM_STORE,
        OP_ROT_LOAD,
        OP_ROT_PREP,
        OP_MUL_DD,
        OP_MUL_HH,
        OP_SQRT1,
        OP_DIV1,
        OP_MUL_TT,
        OP_SQRT2,
        OP_DIV2,
        OP_MUL_TC,
        OP_MUL_TA,
        OP_MUL_CRP,
        OP_MUL_SRQ,
        OP_MUL_SRP,
        OP_MUL_CRQ,
        OP_ROT_END,
        OP_SPH,
        OP_OUT
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE,
        S_TRACE,
        S_KSEL,
        S_NORM_GO,
        S_NORM_WT,
        S_NORM_PUT,
        S_ROT_LD,
        S_ROT_PREP,
        S_MUL_DD,
        S_MUL_HH,
        S_SQ1_GO,
        S_SQ1_WT,
        S_DV1_GO,
        S_DV1_WT,
        S_MUL_TT,
        S_SQ2_GO,
        S_SQ2_WT,
        S_DV2_GO,
        S_DV2_WT,
        S_MUL_TC,
        S_MUL_TA,
        S_MUL_CRP,
        S_MUL_SRQ,
        S_MUL_SRP,
        S_MUL_CRQ,
        S_ROT_END,
        S_SPH,
        S_FINISH
    } t_state;

    typedef struct packed {
        t_op                   op;
        logic [ELEM_IDX_W-1:0] elem;
        t_pair                 pair;
    } t_cmd;

    typedef struct packed {
        logic trace_zero;
        logic apq_zero;
        logic div_busy;
        logic sqrt_busy;
    } t_stat;

endpackage

`default_nettype wire

FILE: hw/rtl/sesel_div.sv
`timescale 1ns / 1ps
`default_nettype none

module sesel_div (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic [sesel_pkg::DIVIDEND_W-1:0] i_dividend,
    input  wire logic [sesel_pkg::DIVISOR_W-1:0]  i_divisor,
    output logic                                  o_busy,
    output logic [sesel_pkg::QUOT_W-1:0]          o_quot
);
    import sesel_pkg::*;

    localparam int REM_W = DIVISOR_W + 1;
    localparam int CNT_W = $clog2(QUOT_W);

    logic                 r_busy;
    logic [CNT_W-1:0]     r_cnt;
    logic [REM_W-1:0]     r_rem;
    logic [QUOT_W-1:0]    r_num;
    logic [QUOT_W-1:0]    r_quot;
    logic [DIVISOR_W-1:0] r_den;
    logic [REM_W-1:0]     trial;
    logic                 fits;

    always_comb begin
        trial = {r_rem[DIVISOR_W-1:0], r_num[QUOT_W-1]};
        fits  = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(QUOT_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= REM_W'(i_dividend[DIVIDEND_W-1:QUOT_W]);
            r_num  <= i_dividend[QUOT_W-1:0];
            r_den  <= i_divisor;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= fits ? (trial - {1'b0, r_den}) : trial;
            r_num  <= {r_num[QUOT_W-2:0], 1'b0};
            r_quot <= {r_quot[QUOT_W-2:0], fits};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

FILE: hw/rtl/sesel_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module sesel_sqrt (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [sesel_pkg::RAD_W-1:0] i_radicand,
    output logic                             o_busy,
    output logic [sesel_pkg::ROOT_W-1:0]     o_root
);
    import sesel_pkg::*;

    localparam int REM_W = ROOT_W + 2;
    localparam int TRY_W = REM_W + 2;
    localparam int CNT_W = $clog2(ROOT_W);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [TRY_W-1:0]  rem2;
    logic [TRY_W-1:0]  trial;
    logic              fits;

    always_comb begin
        rem2  = {r_rem, r_rad[RAD_W-1:RAD_W-2]};
        trial = {2'b00, r_root, 2'b01};
        fits  = (rem2 >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_rem  <= fits ? REM_W'(rem2 - trial) : REM_W'(rem2);
            r_root <= {r_root[ROOT_W-2:0], fits};
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

`default_nettype wire

FILE: hw/rtl/sesel_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module sesel_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire sesel_pkg::t_cmd                   i_cmd,
    output sesel_pkg::t_stat                       o_stat,
    input  wire logic signed [sesel_pkg::MOM_W-1:0] i_mom_x,
    input  wire logic signed [sesel_pkg::MOM_W-1:0] i_mom_y,
    input  wire logic signed [sesel_pkg::MOM_W-1:0] i_mom_z,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [sesel_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [sesel_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                                   o_event_passes,
    output logic [sesel_pkg::SPH_W-1:0]            o_sphericity_value,
    output logic                                   o_empty_event
);
    import sesel_pkg::*;

    localparam logic [ROOT_W-1:0] ELEM_POS = 32'h4000_0000;

    function automatic logic signed [EL_W-1:0] qround(input logic [63:0] p, input logic neg);
        logic [64:0]     t;
        logic [EL_W-1:0] m;
        t = {1'b0, p} + 65'(1 << 27);
        m = t[59:28];
        return neg ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [EL_W-1:0] sat(input logic signed [EL_W+1:0] v);
        if (v > $signed((EL_W+2)'(ELEM_POS))) begin
            return $signed(ELEM_POS);
        end else if (v < -$signed((EL_W+2)'(ELEM_POS))) begin
            return -$signed(ELEM_POS);
        end
        return v[EL_W-1:0];
    endfunction

    function automatic logic [EL_W-1:0] mag(input logic signed [EL_W-1:0] v);
        return v[EL_W-1] ? EL_W'(-v) : EL_W'(v);
    endfunction

    logic signed [SUM_W-1:0] r_sum [N_SUM];
    logic [TRACE_W-1:0]      r_trace;
    logic [K_W-1:0]          r_k;
    logic [TK_W-1:0]         r_tk;
    logic signed [EL_W-1:0]  r_a [N_SUM];
    logic signed [EL_W-1:0]  r_pp, r_qq, r_pq, r_rp, r_rq;
    logic signed [EL_W-1:0]  r_x1, r_x2, r_x3;
    logic [ROOT_W-1:0]       r_ad, r_ah;
    logic                    r_neg;
    logic [63:0]             r_dd, r_prod;
    logic [QUOT_W-1:0]       r_tm, r_cm, r_sm;
    logic [SPH_W-1:0]        r_sph;
    logic [SPH_W-1:0]        r_lower, r_upper;
    logic                    r_upen;

    logic signed [2*MOM_W-1:0] p_xx, p_xy, p_xz, p_yy, p_yz, p_zz;
    logic [TRACE_W-1:0]        trace_sum;
    logic [K_W-1:0]            k_sel;
    logic [TRACE_W-1:0]        trace_sh;
    logic signed [SUM_W-1:0]   sum_e;
    logic [SUM_W-1:0]          mag_e, mag_sh;
    logic [DIVIDEND_W-1:0]     div_num;
    logic [DIVISOR_W-1:0]      div_den;
    logic                      div_start, div_busy;
    logic [QUOT_W-1:0]         quot;
    logic [RAD_W-1:0]          sq_rad;
    logic                      sq_start, sq_busy;
    logic [ROOT_W-1:0]         root;
    logic [ROOT_W-1:0]         mul_a, mul_b;
    logic [EL_W-1:0]           pq_mag;
    logic signed [EL_W:0]      d_diff;
    logic signed [EL_W-1:0]    ta, x4;
    logic signed [EL_W+1:0]    sd0, sd1, sd2, smx, sx;
    logic [EL_W+3:0]           v3;
    logic [SPH_W-1:0]          sph_val;
    logic                      tz;

    assign p_xx = i_mom_x * i_mom_x;
    assign p_xy = i_mom_x * i_mom_y;
    assign p_xz = i_mom_x * i_mom_z;
    assign p_yy = i_mom_y * i_mom_y;
    assign p_yz = i_mom_y * i_mom_z;
    assign p_zz = i_mom_z * i_mom_z;

    assign trace_sum = TRACE_W'($unsigned(r_sum[0])) + TRACE_W'($unsigned(r_sum[3]))
                     + TRACE_W'($unsigned(r_sum[5]));
    assign tz = (r_trace == '0);
    assign pq_mag = mag(r_pq);

    always_comb begin
        k_sel = '0;
        for (int i = 0; i < K_MAX; i++) begin
            if ((r_trace >> i) > TRACE_W'(32'hFFFF_FFFF)) begin
                k_sel = K_W'(i + 1);
            end
        end
        trace_sh = r_trace >> k_sel;
    end

    always_comb begin
        sum_e  = r_sum[i_cmd.elem];
        mag_e  = sum_e[SUM_W-1] ? SUM_W'(-sum_e) : SUM_W'(sum_e);
        mag_sh = mag_e >> r_k;
    end

    always_comb begin
        div_num   = '0;
        div_den   = '0;
        div_start = 1'b0;
        sq_rad    = '0;
        sq_start  = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        case (i_cmd.op)
            OP_NORM_START: begin
                div_num   = {mag_sh[TK_W-1:0], 28'd0};
                div_den   = {1'b0, r_tk};
                div_start = 1'b1;
            end
            OP_DIV1: begin
                div_num   = {r_ah, 28'd0};
                div_den   = {1'b0, r_ad} + {1'b0, root};
                div_start = 1'b1;
            end
            OP_DIV2: begin
                div_num   = DIVIDEND_W'(1) << 56;
                div_den   = {1'b0, root};
                div_start = 1'b1;
            end
            OP_SQRT1: begin
                sq_rad   = r_dd + r_prod;
                sq_start = 1'b1;
            end
            OP_SQRT2: begin
                sq_rad   = (RAD_W'(1) << 56) + r_prod;
                sq_start = 1'b1;
            end
            OP_MUL_DD: begin
                mul_a = r_ad;
                mul_b = r_ad;
            end
            OP_MUL_HH: begin
                mul_a = r_ah;
                mul_b = r_ah;
            end
            OP_MUL_TT: begin
                mul_a = ROOT_W'(quot);
                mul_b = ROOT_W'(quot);
            end
            OP_MUL_TC: begin
                mul_a = ROOT_W'(r_tm);
                mul_b = ROOT_W'(quot);
            end
            OP_MUL_TA: begin
                mul_a = ROOT_W'(r_tm);
                mul_b = pq_mag;
            end
            OP_MUL_CRP: begin
                mul_a = ROOT_W'(r_cm);
                mul_b = mag(r_rp);
            end
            OP_MUL_SRQ: begin
                mul_a = ROOT_W'(r_sm);
                mul_b = mag(r_rq);
            end
            OP_MUL_SRP: begin
                mul_a = ROOT_W'(r_sm);
                mul_b = mag(r_rp);
            end
            OP_MUL_CRQ: begin
                mul_a = ROOT_W'(r_cm);
                mul_b = mag(r_rq);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        d_diff = (EL_W+1)'(r_qq) - (EL_W+1)'(r_pp);
        ta     = qround(r_prod, r_neg ^ r_pq[EL_W-1]);
        x4     = qround(r_prod, r_rq[EL_W-1]);
        sd0    = (EL_W+2)'(r_a[0]);
        sd1    = (EL_W+2)'(r_a[3]);
        sd2    = (EL_W+2)'(r_a[5]);
        smx    = sd0;
        if (sd1 > smx) begin
            smx = sd1;
        end
        if (sd2 > smx) begin
            smx = sd2;
        end
        sx = sd0 + sd1 + sd2 - smx;
        v3 = ((EL_W+4)'($unsigned(sx)) << 1) + (EL_W+4)'($unsigned(sx)) + (EL_W+4)'(1 << 13);
        if (sx <= 0) begin
            sph_val = '0;
        end else if ((v3 >> 14) > (EL_W+4)'(SPH_MAX)) begin
            sph_val = SPH_MAX;
        end else begin
            sph_val = v3[SPH_W+13:14];
        end
    end

    sesel_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_busy     (div_busy),
        .o_quot     (quot)
    );

    sesel_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand (sq_rad),
        .o_busy     (sq_busy),
        .o_root     (root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N_SUM; i++) begin
                r_sum[i] <= '0;
            end
        end else begin
            case (i_cmd.op)
                OP_ACCUM: begin
                    r_sum[0] <= r_sum[0] + SUM_W'(p_xx);
                    r_sum[1] <= r_sum[1] + SUM_W'(p_xy);
                    r_sum[2] <= r_sum[2] + SUM_W'(p_xz);
                    r_sum[3] <= r_sum[3] + SUM_W'(p_yy);
                    r_sum[4] <= r_sum[4] + SUM_W'(p_yz);
                    r_sum[5] <= r_sum[5] + SUM_W'(p_zz);
                end
                OP_OUT: begin
                    for (int i = 0; i < N_SUM; i++) begin
                        r_sum[i] <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower <= LOWER_RST;
            r_upper <= UPPER_RST;
            r_upen  <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_LOWER_THRESHOLD: r_lower <= i_cfg_data;
                CFG_UPPER_THRESHOLD: r_upper <= i_cfg_data;
                CFG_UPPER_ENABLE:    r_upen  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (i_cmd.op)
            OP_TRACE: begin
                r_trace <= trace_sum;
                r_sph   <= '0;
            end
            OP_KSEL: begin
                r_k  <= k_sel;
                r_tk <= trace_sh[TK_W-1:0];
            end
            OP_NORM_STORE: begin
                r_a[i_cmd.elem] <= sum_e[SUM_W-1] ? -$signed(EL_W'(quot)) : $signed(EL_W'(quot));
            end
            OP_ROT_LOAD: begin
                case (i_cmd.pair)
                    PAIR_01: begin
                        r_pp <= r_a[0]; r_qq <= r_a[3]; r_pq <= r_a[1];
                        r_rp <= r_a[2]; r_rq <= r_a[4];
                    end
                    PAIR_02: begin
                        r_pp <= r_a[0]; r_qq <= r_a[5]; r_pq <= r_a[2];
                        r_rp <= r_a[1]; r_rq <= r_a[4];
                    end
                    default: begin
                        r_pp <= r_a[3]; r_qq <= r_a[5]; r_pq <= r_a[4];
                        r_rp <= r_a[1]; r_rq <= r_a[2];
                    end
                endcase
            end
            OP_ROT_PREP: begin
                r_ad  <= d_diff[EL_W] ? EL_W'(-d_diff) : EL_W'(d_diff);
                r_ah  <= {pq_mag[EL_W-2:0], 1'b0};
                r_neg <= d_diff[EL_W] != r_pq[EL_W-1];
            end
            OP_MUL_HH: r_dd <= r_prod;
            OP_MUL_TT: r_tm <= quot;
            OP_MUL_TC: r_cm <= quot;
            OP_MUL_TA: r_sm <= QUOT_W'(qround(r_prod, 1'b0));
            OP_MUL_CRP: begin
                r_pp <= sat((EL_W+2)'(r_pp) - (EL_W+2)'(ta));
                r_qq <= sat((EL_W+2)'(r_qq) + (EL_W+2)'(ta));
                r_pq <= '0;
            end
            OP_MUL_SRQ: r_x1 <= qround(r_prod, r_rp[EL_W-1]);
            OP_MUL_SRP: r_x2 <= qround(r_prod, r_neg ^ r_rq[EL_W-1]);
            OP_MUL_CRQ: r_x3 <= qround(r_prod, r_neg ^ r_rp[EL_W-1]);
            OP_ROT_END: begin
                case (i_cmd.pair)
                    PAIR_01: begin
                        r_a[0] <= r_pp; r_a[3] <= r_qq; r_a[1] <= '0;
                        r_a[2] <= sat((EL_W+2)'(r_x1) - (EL_W+2)'(r_x2));
                        r_a[4] <= sat((EL_W+2)'(r_x3) + (EL_W+2)'(x4));
                    end
                    PAIR_02: begin
                        r_a[0] <= r_pp; r_a[5] <= r_qq; r_a[2] <= '0;
                        r_a[1] <= sat((EL_W+2)'(r_x1) - (EL_W+2)'(r_x2));
                        r_a[4] <= sat((EL_W+2)'(r_x3) + (EL_W+2)'(x4));
                    end
                    default: begin
                        r_a[3] <= r_pp; r_a[5] <= r_qq; r_a[4] <= '0;
                        r_a[1] <= sat((EL_W+2)'(r_x1) - (EL_W+2)'(r_x2));
                        r_a[2] <= sat((EL_W+2)'(r_x3) + (EL_W+2)'(x4));
                    end
                endcase
            end
            OP_SPH: r_sph <= sph_val;
            OP_OUT: begin
                o_event_passes     <= !tz && (r_sph >= r_lower) && (!r_upen || (r_sph < r_upper));
                o_sphericity_value <= r_sph;
                o_empty_event      <= tz;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_stat.trace_zero = tz;
        o_stat.apq_zero   = (r_pq == '0);
        o_stat.div_busy   = div_busy;
        o_stat.sqrt_busy  = sq_busy;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/sesel_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sesel_ctrl #(
    parameter int MAX_PARTICLES = sesel_pkg::MAX_PARTICLES_DEF,
    parameter int JACOBI_SWEEPS = sesel_pkg::JACOBI_SWEEPS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic             i_last_particle,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output sesel_pkg::t_cmd       o_cmd,
    input  wire sesel_pkg::t_stat i_stat
);
    import sesel_pkg::*;

    localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
    localparam int SW_W  = $clog2(JACOBI_SWEEPS);

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [ELEM_IDX_W-1:0] r_elem, n_elem;
    t_pair                 r_pair, n_pair;
    logic [SW_W-1:0]       r_sweep, n_sweep;
    logic                  r_out_valid, n_out_valid;
    logic                  accept, room, slot_free, last_rot;

    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign room      = (r_count < CNT_W'(MAX_PARTICLES));
    assign slot_free = !r_out_valid || i_out_ready;
    assign last_rot  = (r_pair == PAIR_12) && (r_sweep == SW_W'(JACOBI_SWEEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_elem      <= '0;
            r_pair      <= PAIR_01;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_elem      <= n_elem;
            r_pair      <= n_pair;
            r_sweep     <= n_sweep;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_elem      = r_elem;
        n_pair      = r_pair;
        n_sweep     = r_sweep;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_last_particle) begin
                        n_count = '0;
                        n_state = S_TRACE;
                    end else if (room) begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            S_TRACE: n_state = S_KSEL;
            S_KSEL: begin
                n_elem  = '0;
                n_state = i_stat.trace_zero ? S_FINISH : S_NORM_GO;
            end
            S_NORM_GO: n_state = S_NORM_WT;
            S_NORM_WT: begin
                if (!i_stat.div_busy) begin
                    n_state = S_NORM_PUT;
                end
            end
            S_NORM_PUT: begin
                if (r_elem == ELEM_LAST) begin
                    n_pair  = PAIR_01;
                    n_sweep = '0;
                    n_state = S_ROT_LD;
                end else begin
                    n_elem  = r_elem + 1'b1;
                    n_state = S_NORM_GO;
                end
            end
            S_ROT_LD: n_state = S_ROT_PREP;
            S_ROT_PREP, S_ROT_END: begin
                if ((r_state == S_ROT_PREP) && !i_stat.apq_zero) begin
                    n_state = S_MUL_DD;
                end else if (last_rot) begin
                    n_state = S_SPH;
                end else begin
                    n_state = S_ROT_LD;
                    case (r_pair)
                        PAIR_01: n_pair = PAIR_02;
                        PAIR_02: n_pair = PAIR_12;
                        default: begin
                            n_pair  = PAIR_01;
                            n_sweep = r_sweep + 1'b1;
                        end
                    endcase
                end
            end
            S_MUL_DD: n_state = S_MUL_HH;
            S_MUL_HH: n_state = S_SQ1_GO;
            S_SQ1_GO: n_state = S_SQ1_WT;
            S_SQ1_WT: begin
                if (!i_stat.sqrt_busy) begin
                    n_state = S_DV1_GO;
                end
            end
            S_DV1_GO: n_state = S_DV1_WT;
            S_DV1_WT: begin
                if (!i_stat.div_busy) begin
                    n_state = S_MUL_TT;
                end
            end
            S_MUL_TT: n_state = S_SQ2_GO;
            S_SQ2_GO: n_state = S_SQ2_WT;
            S_SQ2_WT: begin
                if (!i_stat.sqrt_busy) begin
                    n_state = S_DV2_GO;
                end
            end
            S_DV2_GO: n_state = S_DV2_WT;
            S_DV2_WT: begin
                if (!i_stat.div_busy) begin
                    n_state = S_MUL_TC;
                end
            end
            S_MUL_TC:  n_state = S_MUL_TA;
            S_MUL_TA:  n_state = S_MUL_CRP;
            S_MUL_CRP: n_state = S_MUL_SRQ;
            S_MUL_SRQ: n_state = S_MUL_SRP;
            S_MUL_SRP: n_state = S_MUL_CRQ;
            S_MUL_CRQ: n_state = S_ROT_END;
            S_SPH:     n_state = S_FINISH;
            S_FINISH: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.elem = r_elem;
        o_cmd.pair = r_pair;
        case (r_state)
            S_IDLE:     o_cmd.op = (accept && room) ? OP_ACCUM : OP_NOP;
            S_TRACE:    o_cmd.op = OP_TRACE;
            S_KSEL:     o_cmd.op = OP_KSEL;
            S_NORM_GO:  o_cmd.op = OP_NORM_START;
            S_NORM_PUT: o_cmd.op = OP_NORM_STORE;
            S_ROT_LD:   o_cmd.op = OP_ROT_LOAD;
            S_ROT_PREP: o_cmd.op = OP_ROT_PREP;
            S_MUL_DD:   o_cmd.op = OP_MUL_DD;
            S_MUL_HH:   o_cmd.op = OP_MUL_HH;
            S_SQ1_GO:   o_cmd.op = OP_SQRT1;
            S_DV1_GO:   o_cmd.op = OP_DIV1;
            S_MUL_TT:   o_cmd.op = OP_MUL_TT;
            S_SQ2_GO:   o_cmd.op = OP_SQRT2;
            S_DV2_GO:   o_cmd.op = OP_DIV2;
            S_MUL_TC:   o_cmd.op = OP_MUL_TC;
            S_MUL_TA:   o_cmd.op = OP_MUL_TA;
            S_MUL_CRP:  o_cmd.op = OP_MUL_CRP;
            S_MUL_SRQ:  o_cmd.op = OP_MUL_SRQ;
            S_MUL_SRP:  o_cmd.op = OP_MUL_SRP;
            S_MUL_CRQ:  o_cmd.op = OP_MUL_CRQ;
            S_ROT_END:  o_cmd.op = OP_ROT_END;
            S_SPH:      o_cmd.op = OP_SPH;
            S_FINISH:   o_cmd.op = slot_free ? OP_OUT : OP_NOP;
            default:    o_cmd.op = OP_NOP;
        endcase
        o_in_ready  = (r_state == S_IDLE);
        o_out_valid = r_out_valid;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/sphericity_event_selector_top.sv
// Channel  | Handshake                 | Word
// ---------+---------------------------+-----------------------------------------------
// in       | i_in_valid / o_in_ready   | i_mom_x, i_mom_y, i_mom_z, i_last_particle
// out      | o_out_valid / i_out_ready | o_event_passes, o_sphericity_value, o_empty_event
// cfg      | i_cfg_wr_en               | i_cfg_index, i_cfg_data
//
// Particles that are not last are taken back to back while idle. A last particle starts
// the solve: normalization (six divides), then per rotation two square roots, two
// divides and one shared multiplier, a rotation with a zero off-diagonal term being
// skipped; 3 rotations per sweep, JACOBI_SWEEPS sweeps (6 by default).
// The result sits in an output register; a pending result stalls only the next close.
// Synchronous active-low reset clears sums and counters and resets the configuration.
`timescale 1ns / 1ps
`default_nettype none

module sphericity_event_selector_top #(
    parameter int MAX_PARTICLES = sesel_pkg::MAX_PARTICLES_DEF,
    parameter int JACOBI_SWEEPS = sesel_pkg::JACOBI_SWEEPS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic signed [sesel_pkg::MOM_W-1:0] i_mom_x,
    input  wire logic signed [sesel_pkg::MOM_W-1:0] i_mom_y,
    input  wire logic signed [sesel_pkg::MOM_W-1:0] i_mom_z,
    input  wire logic                               i_last_particle,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic                                    o_event_passes,
    output logic [sesel_pkg::SPH_W-1:0]             o_sphericity_value,
    output logic                                    o_empty_event,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [sesel_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [sesel_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import sesel_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    sesel_ctrl #(
        .MAX_PARTICLES (MAX_PARTICLES),
        .JACOBI_SWEEPS (JACOBI_SWEEPS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_last_particle (i_last_particle),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_cmd           (cmd),
        .i_stat          (stat)
    );

    sesel_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_mom_x            (i_mom_x),
        .i_mom_y            (i_mom_y),
        .i_mom_z            (i_mom_z),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_event_passes     (o_event_passes),
        .o_sphericity_value (o_sphericity_value),
        .o_empty_event      (o_empty_event)
    );

endmodule

`default_nettype wire

FILE: bench/sphericity_event_selector_top_test.sv
`timescale 1ns / 1ps

module sphericity_event_selector_top_test;
    import sesel_pkg::*;

    localparam int N_PART    = 64;
    localparam int N_SWEEP   = 6;
    localparam longint ELIM  = 64'sd1 <<< 30;
    localparam int WDOG_LIM  = 40000;
    localparam int SETTLE    = 3500;

    typedef struct {
        bit        passes;
        bit [15:0] sph;
        bit        empty;
    } t_verdict;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic signed [MOM_W-1:0] i_mom_x = '0;
    logic signed [MOM_W-1:0] i_mom_y = '0;
    logic signed [MOM_W-1:0] i_mom_z = '0;
    logic                    i_last_particle = 1'b0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic                    o_event_passes;
    logic [SPH_W-1:0]        o_sphericity_value;
    logic                    o_empty_event;
    logic                    i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = CFG_LOWER_THRESHOLD;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;

    sphericity_event_selector_top DUT (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // model state
    bit [15:0] lower_thr, upper_thr;
    bit        upper_en;
    longint    sums [6];
    int        n_accum;
    longint    mtx [3][3];
    t_verdict  pending_verdicts [$];
    int        n_errors;
    bit        running;
    int        quiet_cycles;
    int        stall_left;
    bit        free_flow;

    function automatic longint clip(longint v);
        if (v > ELIM) return ELIM;
        if (v < -ELIM) return -ELIM;
        return v;
    endfunction

    function automatic longint unsigned magn(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        longint unsigned p;
        p = (magn(a) * magn(b) + (64'd1 << 27)) >> 28;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic void jacobi_rotate(int p, int q);
        int r;
        longint apq, d, h, t, c, s, ta, arp, arq, nrp, nrq;
        longint unsigned ad, ah, root, tm, qd, cm, sm;
        bit neg;
        r = 3 - p - q;
        apq = mtx[p][q];
        if (apq == 0) return;
        d = mtx[q][q] - mtx[p][p];
        h = 2 * apq;
        ad = magn(d);
        ah = magn(h);
        root = floor_sqrt(ad * ad + ah * ah);
        tm = (ah << 28) / (ad + root);
        neg = (d < 0) != (h < 0);
        qd = floor_sqrt((64'd1 << 56) + tm * tm);
        cm = (64'd1 << 56) / qd;
        sm = (tm * cm + (64'd1 << 27)) >> 28;
        t = neg ? -longint'(tm) : longint'(tm);
        c = longint'(cm);
        s = neg ? -longint'(sm) : longint'(sm);
        ta = qmul(t, apq);
        mtx[p][p] = clip(mtx[p][p] - ta);
        mtx[q][q] = clip(mtx[q][q] + ta);
        mtx[p][q] = 0;
        mtx[q][p] = 0;
        arp = mtx[r][p];
        arq = mtx[r][q];
        nrp = clip(qmul(c, arp) - qmul(s, arq));
        nrq = clip(qmul(s, arp) + qmul(c, arq));
        mtx[r][p] = nrp; mtx[p][r] = nrp;
        mtx[r][q] = nrq; mtx[q][r] = nrq;
    endfunction

    function automatic longint scaled_entry(longint v, int k, longint unsigned tk);
        longint sv;
        sv = longint'(((magn(v) >> k) << 28) / tk);
        return clip(v < 0 ? -sv : sv);
    endfunction

    function automatic bit [15:0] calc_sphericity(longint unsigned trace);
        int k;
        longint unsigned tk, v;
        longint mx, x;
        k = 0;
        while ((trace >> k) >= (64'd1 << 32)) k++;
        tk = trace >> k;
        mtx[0][0] = scaled_entry(sums[0], k, tk);
        mtx[0][1] = scaled_entry(sums[1], k, tk);
        mtx[0][2] = scaled_entry(sums[2], k, tk);
        mtx[1][1] = scaled_entry(sums[3], k, tk);
        mtx[1][2] = scaled_entry(sums[4], k, tk);
        mtx[2][2] = scaled_entry(sums[5], k, tk);
        mtx[1][0] = mtx[0][1];
        mtx[2][0] = mtx[0][2];
        mtx[2][1] = mtx[1][2];
        for (int sw = 0; sw < N_SWEEP; sw++) begin
            jacobi_rotate(0, 1);
            jacobi_rotate(0, 2);
            jacobi_rotate(1, 2);
        end
        mx = mtx[0][0];
        if (mtx[1][1] > mx) mx = mtx[1][1];
        if (mtx[2][2] > mx) mx = mtx[2][2];
        x = mtx[0][0] + mtx[1][1] + mtx[2][2] - mx;
        if (x <= 0) return 16'd0;
        v = (longint'(x) * 3 + (64'd1 << 13)) >> 14;
        if (v > 32768) v = 32768;
        return v[15:0];
    endfunction

    function automatic void accept_particle(longint px, longint py, longint pz, bit last);
        longint unsigned trace;
        t_verdict vd;
        if (n_accum < N_PART) begin
            sums[0] += px * px;
            sums[1] += px * py;
            sums[2] += px * pz;
            sums[3] += py * py;
            sums[4] += py * pz;
            sums[5] += pz * pz;
            n_accum++;
        end
        if (!last) return;
        trace = longint'(sums[0]) + longint'(sums[3]) + longint'(sums[5]);
        vd.empty = (trace == 0);
        vd.sph = 16'd0;
        vd.passes = 1'b0;
        if (!vd.empty) begin
            vd.sph = calc_sphericity(trace);
            vd.passes = (vd.sph >= lower_thr) && (!upper_en || vd.sph < upper_thr);
        end
        pending_verdicts.push_back(vd);
        for (int i = 0; i < 6; i++) sums[i] = 0;
        n_accum = 0;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_particle(logic signed [15:0] x, logic signed [15:0] y,
                                 logic signed [15:0] z, bit last);
        int gap;
        gap = free_flow ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_mom_x         <= x;
        i_mom_y         <= y;
        i_mom_z         <= z;
        i_last_particle <= last;
        do @(posedge i_clk); while (!o_in_ready);
        accept_particle(x, y, z, last);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == CFG_LOWER_THRESHOLD) lower_thr = val;
        else if (idx == CFG_UPPER_THRESHOLD) upper_thr = val;
        else if (idx == CFG_UPPER_ENABLE) upper_en = val[0];
    endtask

    task automatic set_window(logic [15:0] lo, logic [15:0] hi, bit en);
        write_reg(CFG_LOWER_THRESHOLD, lo);
        write_reg(CFG_UPPER_THRESHOLD, hi);
        write_reg(CFG_UPPER_ENABLE, {15'd0, en});
    endtask

    function automatic logic signed [15:0] rand_mom();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return 16'($urandom);
        if (r < 6) return 16'($urandom_range(0, 200) - 100);
        if (r < 7) return 16'sh0;
        if (r < 8) return 16'sh7fff;
        if (r < 9) return 16'sh8000;
        return 16'($urandom_range(0, 4000) - 2000);
    endfunction

    task automatic send_event(int n);
        logic signed [15:0] ax, ay, az;
        int shape;
        shape = $urandom_range(0, 3);
        ax = rand_mom(); ay = rand_mom(); az = rand_mom();
        for (int i = 0; i < n; i++) begin
            if (shape == 0)
                send_particle(ax, ay, az, i == n - 1);
            else if (shape == 1)
                send_particle(ax >>> $urandom_range(0, 8), ay >>> $urandom_range(0, 8),
                              az, i == n - 1);
            else
                send_particle(rand_mom(), rand_mom(), rand_mom(), i == n - 1);
        end
    endtask

    task automatic test_extremes();
        send_particle(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1);
        send_particle(16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
        send_particle(16'sh7fff, 16'sh8000, 16'sh0, 1'b0);
        send_particle(16'sh0, 16'sh7fff, 16'sh8000, 1'b1);
        send_particle(16'sh1000, 16'sh0, 16'sh0, 1'b0);
        send_particle(16'sh0, 16'sh1000, 16'sh0, 1'b0);
        send_particle(16'sh0, 16'sh0, 16'sh1000, 1'b1);
        send_particle(16'sh0, 16'sh0, 16'sh0, 1'b1);
        send_particle(16'sh0, 16'sh0, 16'sh0, 1'b0);
        send_particle(16'sh0, 16'sh0, 16'sh0, 1'b1);
        send_particle(-16'sd1, 16'sd1, 16'sd0, 1'b1);
        drain();
    endtask

    task automatic test_overflow();
        for (int i = 0; i < 70; i++)
            send_particle(i < 64 ? 16'sd300 : 16'sh7fff, 16'sd0,
                          i < 64 ? 16'sd0 : 16'sh8000, i == 69);
        drain();
    endtask

    task automatic test_window();
        set_window(16'd32768, 16'd32768, 1'b1);
        send_particle(16'sd100, 16'sd0, 16'sd0, 1'b0);
        send_particle(16'sd0, 16'sd100, 16'sd0, 1'b0);
        send_particle(16'sd0, 16'sd0, 16'sd100, 1'b1);
        drain();
        set_window(16'hffff, 16'hffff, 1'b1);
        send_particle(16'sd100, 16'sd0, 16'sd0, 1'b0);
        send_particle(16'sd0, 16'sd100, 16'sd0, 1'b0);
        send_particle(16'sd0, 16'sd0, 16'sd100, 1'b1);
        drain();
        set_window(16'd0, 16'd0, 1'b1);
        send_particle(16'sd100, 16'sd0, 16'sd0, 1'b1);
        drain();
    endtask

    task automatic test_random(int n_items);
        int sent, n, next_cfg;
        sent = 0;
        next_cfg = 0;
        while (sent < n_items) begin
            if (sent >= next_cfg) begin
                next_cfg += 320;
                drain();
                set_window(16'($urandom_range(0, 32768)), 16'($urandom_range(0, 65535)),
                           1'($urandom_range(0, 1)));
                free_flow = $urandom_range(0, 3) == 0;
            end
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 72)
                                             : $urandom_range(1, 12);
            send_event(n);
            sent += n;
        end
        drain();
    endtask

    always @(posedge i_clk) begin
        if (free_flow) begin
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            stall_left  <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 200)
                                                        : $urandom_range(0, 2);
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_verdict vd;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_verdicts.size() == 0) begin
                $error("unexpected result word");
                n_errors++;
            end else begin
                vd = pending_verdicts.pop_front();
                if (o_event_passes !== vd.passes) begin
                    $error("event_passes exp %0d got %0d", vd.passes, o_event_passes);
                    n_errors++;
                end
                if (o_sphericity_value !== vd.sph) begin
                    $error("sphericity_value exp %0d got %0d", vd.sph,
                           o_sphericity_value);
                    n_errors++;
                end
                if (o_empty_event !== vd.empty) begin
                    $error("empty_event exp %0d got %0d", vd.empty, o_empty_event);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!running || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_LIM) begin
            $display("sphericity_event_selector_top: mismatch");
            $finish;
        end
    end

    initial begin
        lower_thr = 16'd0;
        upper_thr = 16'd32768;
        upper_en  = 1'b0;
        for (int i = 0; i < 6; i++) sums[i] = 0;
        n_accum = 0;
        n_errors = 0;
        running = 1'b0;
        quiet_cycles = 0;
        stall_left = 0;
        free_flow = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        running = 1'b1;
        test_extremes();
        test_overflow();
        test_window();
        test_random(1900);
        repeat (SETTLE) @(posedge i_clk);
        if (n_errors == 0 && pending_verdicts.size() == 0)
            $display("sphericity_event_selector_top: match");
        else
            $display("sphericity_event_selector_top: mismatch");
        $finish;
    end

endmodule
